@@ rtl/core/pctd_pkg.sv @@
package pctd_pkg;

    localparam int CHAR_BITS = 16;
    localparam int BYTE_BITS = 8;
    localparam int MAX_RESULTS = 3;
    localparam int CNT_BITS = 2;

    localparam logic [CHAR_BITS-1:0] PCT_CHAR = CHAR_BITS'(8'h25);
    localparam logic [4:0] HEX_NONE = 5'd16;

    typedef struct packed {
        logic [CHAR_BITS-1:0] char_in;
        logic                 last_in;
    } src_req_t;

    typedef struct packed {
        logic [CHAR_BITS-1:0] char_out;
        logic                 has_char;
        logic                 last_out;
    } dst_req_t;

    typedef enum logic [2:0] {
        PH_IDLE  = 3'b001,
        PH_PCT   = 3'b010,
        PH_DIGIT = 3'b100
    } phase_t;

    // Results of one request, slot 0 goes out first
    typedef struct packed {
        logic [CNT_BITS-1:0]             cnt;
        dst_req_t [MAX_RESULTS-1:0]      slot;
        phase_t                          phase;
        logic [BYTE_BITS-1:0]            first_byte;
    } decode_t;

    // Digit value 0..15, or HEX_NONE for a byte that is not a hex digit
    function automatic logic [4:0] hex_value(input logic [BYTE_BITS-1:0] b);
        logic [4:0] v;
        v = HEX_NONE;
        if (b >= 8'h30 && b <= 8'h39) v = 5'(b - 8'h30);
        else if (b >= 8'h41 && b <= 8'h46) v = 5'(b - 8'h41 + 8'd10);
        else if (b >= 8'h61 && b <= 8'h66) v = 5'(b - 8'h61 + 8'd10);
        return v;
    endfunction

endpackage

@@ rtl/core/pctd_decode.sv @@
module pctd_decode
    import pctd_pkg::*;
(
    input  src_req_t             req,
    input  phase_t               phase,
    input  logic [BYTE_BITS-1:0] first_byte,
    output decode_t              dec
);

    logic [BYTE_BITS-1:0] low;
    logic [4:0]           h1;
    logic [4:0]           h2;
    dst_req_t             marker;

    assign low = req.char_in[BYTE_BITS-1:0];
    assign h1  = hex_value(first_byte);
    assign h2  = hex_value(low);

    assign marker = '{char_out: '0, has_char: 1'b0, last_out: 1'b1};

    always_comb
    begin
        dec.cnt        = '0;
        dec.slot       = '0;
        dec.phase      = PH_IDLE;
        dec.first_byte = first_byte;
        unique case (phase)
            PH_PCT:
            begin
                dec.first_byte = low;
                if (req.last_in)
                begin
                    dec.cnt     = CNT_BITS'(1);
                    dec.slot[0] = marker;
                end
                else
                begin
                    dec.phase = PH_DIGIT;
                end
            end
            PH_DIGIT:
            begin
                if (h1 == HEX_NONE)
                begin
                    // bad escape: replay '%' and both low bytes
                    dec.cnt     = CNT_BITS'(3);
                    dec.slot[0] = '{char_out: PCT_CHAR, has_char: 1'b1, last_out: 1'b0};
                    dec.slot[1] = '{char_out: CHAR_BITS'(first_byte), has_char: 1'b1,
                                    last_out: 1'b0};
                    dec.slot[2] = '{char_out: CHAR_BITS'(low), has_char: 1'b1,
                                    last_out: req.last_in};
                end
                else if (h2 == HEX_NONE)
                begin
                    dec.cnt     = CNT_BITS'(1);
                    dec.slot[0] = '{char_out: CHAR_BITS'(h1[3:0]), has_char: 1'b1,
                                    last_out: req.last_in};
                end
                else
                begin
                    dec.cnt     = CNT_BITS'(1);
                    dec.slot[0] = '{char_out: CHAR_BITS'({h1[3:0], h2[3:0]}), has_char: 1'b1,
                                    last_out: req.last_in};
                end
            end
            default:
            begin
                if (req.char_in == PCT_CHAR)
                begin
                    if (req.last_in)
                    begin
                        dec.cnt     = CNT_BITS'(1);
                        dec.slot[0] = marker;
                    end
                    else
                    begin
                        dec.phase = PH_PCT;
                    end
                end
                else
                begin
                    dec.cnt     = CNT_BITS'(1);
                    dec.slot[0] = '{char_out: req.char_in, has_char: 1'b1,
                                    last_out: req.last_in};
                end
            end
        endcase
    end

endmodule

@@ rtl/core/percent_escape_decoder.sv @@
// A request is registered in the input stage, then decoded into the result
// queue. Throughput: one request per cycle while dst does not stall; a bad
// escape yields three results and holds the source side while they drain.
// Reset (rst_n low, asynchronous): both stages empty, no escape pending,
// saved first digit cleared.
module percent_escape_decoder
    import pctd_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     src_valid,
    output logic     src_stall,
    input  src_req_t src_data,
    output logic     dst_valid,
    input  logic     dst_stall,
    output dst_req_t dst_data
);

    logic                  in_vld_reg;
    logic                  in_vld_next;
    src_req_t              in_data_reg;
    phase_t                phase_reg;
    logic [BYTE_BITS-1:0]  first_reg;
    logic [CNT_BITS-1:0]   cnt_reg;
    logic [CNT_BITS-1:0]   cnt_next;
    dst_req_t [MAX_RESULTS-1:0] slot_reg;
    dst_req_t [MAX_RESULTS-1:0] slot_next;

    decode_t dec;
    logic    take;
    logic    pop;
    logic    advance;

    pctd_decode u_decode (
        .req        (in_data_reg),
        .phase      (phase_reg),
        .first_byte (first_reg),
        .dec        (dec)
    );

    assign pop     = dst_valid && !dst_stall;
    // advance the decoded request once the queue is empty after this cycle
    assign advance = in_vld_reg &&
                     (cnt_reg == '0 || (cnt_reg == CNT_BITS'(1) && pop));
    assign src_stall = in_vld_reg && !advance;
    assign take      = src_valid && !src_stall;

    assign dst_valid = (cnt_reg != '0);
    assign dst_data  = slot_reg[0];

    always_comb
    begin
        in_vld_next = in_vld_reg;
        if (take)
            in_vld_next = 1'b1;
        else if (advance)
            in_vld_next = 1'b0;
    end

    always_comb
    begin
        cnt_next  = cnt_reg;
        slot_next = slot_reg;
        if (advance)
        begin
            cnt_next  = dec.cnt;
            slot_next = dec.slot;
        end
        else if (pop)
        begin
            cnt_next  = cnt_reg - CNT_BITS'(1);
            slot_next = {dst_req_t'('0), slot_reg[MAX_RESULTS-1:1]};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg <= 1'b0;
            cnt_reg    <= '0;
            phase_reg  <= PH_IDLE;
            first_reg  <= '0;
        end
        else
        begin
            in_vld_reg <= in_vld_next;
            cnt_reg    <= cnt_next;
            if (advance)
            begin
                phase_reg <= dec.phase;
                first_reg <= dec.first_byte;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
            in_data_reg <= src_data;
        slot_reg <= slot_next;
    end

endmodule

@@ rtl/core/pctd_checker.sv @@
module pctd_checker
    import pctd_pkg::*;
(
    input logic     clk,
    input logic     rst_n,
    input logic     src_valid,
    input logic     src_stall,
    input src_req_t src_data,
    input logic     dst_valid,
    input logic     dst_stall,
    input dst_req_t dst_data
);

    // hold a stalled source request
    a_src_hold: assert property (@(posedge clk) disable iff (!rst_n)
        src_valid && src_stall |=> src_valid && $stable(src_data))
        else $error("stalled request changed");

    // hold a stalled result
    a_dst_hold: assert property (@(posedge clk) disable iff (!rst_n)
        dst_valid && dst_stall |=> dst_valid && $stable(dst_data))
        else $error("stalled result changed");

    // a bare end marker always closes the string and carries no character
    a_marker_last: assert property (@(posedge clk) disable iff (!rst_n)
        dst_valid && !dst_data.has_char |-> dst_data.last_out)
        else $error("end marker without last");

    a_marker_zero: assert property (@(posedge clk) disable iff (!rst_n)
        dst_valid && !dst_data.has_char |-> dst_data.char_out == '0)
        else $error("end marker with nonzero char");

    // no result can show up the cycle after reset releases
    a_reset_empty: assert property (@(posedge clk)
        !rst_n |=> !dst_valid)
        else $error("result present right after reset");

endmodule

bind percent_escape_decoder pctd_checker u_pctd_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .src_valid (src_valid),
    .src_stall (src_stall),
    .src_data  (src_data),
    .dst_valid (dst_valid),
    .dst_stall (dst_stall),
    .dst_data  (dst_data)
);

@@ tb/percent_escape_decoder_tb.sv @@
`timescale 1ns / 1ps

module percent_escape_decoder_tb;
    import pctd_pkg::*;

    // Tracks the escape state of the stream and holds the results still owed
    class pct_scoreboard;
        dst_req_t        owed_q[$];
        phase_t          phase = PH_IDLE;
        logic [7:0]      held_byte = '0;
        int              mismatches = 0;
        int              results_seen = 0;
        int              n_decoded = 0;
        int              n_single = 0;
        int              n_bad = 0;
        int              n_cut = 0;

        // Digit value in [3:0], bit 4 set when the byte is not a hex digit
        function logic [4:0] hex_digit(logic [7:0] b);
            if (b >= 8'h30 && b <= 8'h39)
                return {1'b0, b[3:0]};
            if ((b >= 8'h41 && b <= 8'h46) || (b >= 8'h61 && b <= 8'h66))
                return {1'b0, b[3:0] + 4'd9};
            return 5'h10;
        endfunction

        function void owe(logic [CHAR_BITS-1:0] c, logic has, logic last);
            dst_req_t d;
            d.char_out = c;
            d.has_char = has;
            d.last_out = last;
            owed_q.push_back(d);
        endfunction

        function void note_request(src_req_t r);
            logic [7:0] lo;
            logic [4:0] d1;
            logic [4:0] d2;
            lo = r.char_in[7:0];
            case (phase)
                PH_PCT:
                begin
                    held_byte = lo;
                    if (r.last_in)
                    begin
                        owe('0, 1'b0, 1'b1);
                        n_cut++;
                        phase = PH_IDLE;
                    end
                    else
                        phase = PH_DIGIT;
                end
                PH_DIGIT:
                begin
                    d1 = hex_digit(held_byte);
                    d2 = hex_digit(lo);
                    if (d1[4])
                    begin
                        // bad escape: pass all three through, last only on the third
                        owe(PCT_CHAR, 1'b1, 1'b0);
                        owe({8'h00, held_byte}, 1'b1, 1'b0);
                        owe({8'h00, lo}, 1'b1, r.last_in);
                        n_bad++;
                    end
                    else if (d2[4])
                    begin
                        owe({12'h000, d1[3:0]}, 1'b1, r.last_in);
                        n_single++;
                    end
                    else
                    begin
                        owe({8'h00, d1[3:0], d2[3:0]}, 1'b1, r.last_in);
                        n_decoded++;
                    end
                    phase = PH_IDLE;
                end
                default:
                begin
                    if (r.char_in == PCT_CHAR)
                    begin
                        if (r.last_in)
                        begin
                            owe('0, 1'b0, 1'b1);
                            n_cut++;
                        end
                        else
                            phase = PH_PCT;
                    end
                    else
                        owe(r.char_in, 1'b1, r.last_in);
                end
            endcase
        endfunction

        function void check_result(dst_req_t got);
            dst_req_t want;
            results_seen++;
            if (owed_q.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("result %0d with none owed: char %h has %b last %b",
                             results_seen, got.char_out, got.has_char, got.last_out);
                return;
            end
            want = owed_q.pop_front();
            if (got !== want)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("result %0d: expected char %h has %b last %b, got %h %b %b",
                             results_seen, want.char_out, want.has_char, want.last_out,
                             got.char_out, got.has_char, got.last_out);
            end
        endfunction

        function int pending();
            return owed_q.size();
        endfunction
    endclass

    logic     clk = 1'b0;
    logic     rst_n;
    logic     src_valid = 1'b0;
    logic     src_stall;
    src_req_t src_data = '0;
    logic     dst_valid;
    logic     dst_stall = 1'b0;
    dst_req_t dst_data;

    pct_scoreboard  sb = new;
    logic [15:0]    str_q[$];
    logic           src_quiet = 1'b0;
    logic           dst_quiet = 1'b0;
    int             requests_sent = 0;

    percent_escape_decoder DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .src_valid(src_valid),
        .src_stall(src_stall),
        .src_data (src_data),
        .dst_valid(dst_valid),
        .dst_stall(dst_stall),
        .dst_data (dst_data)
    );

    initial
    begin
        forever #4 clk = ~clk;
    end

    initial
    begin
        #2_000_000;
        $display("percent_escape_decoder verification failed");
        $finish;
    end

    // Hold the request through stalls, note it once it is taken
    task automatic send_request(input src_req_t r);
        int gap;
        gap = src_quiet ? 0 : $urandom_range(0, 9);
        repeat (gap)
        begin
            @(negedge clk);
            src_valid <= 1'b0;
        end
        @(negedge clk);
        src_valid <= 1'b1;
        src_data  <= r;
        do
            @(posedge clk);
        while (src_stall !== 1'b0);
        sb.note_request(r);
        requests_sent++;
    endtask

    task automatic send_string();
        src_req_t r;
        for (int i = 0; i < str_q.size(); i++)
        begin
            r.char_in = str_q[i];
            r.last_in = (i == str_q.size() - 1);
            send_request(r);
        end
    endtask

    task automatic drain();
        @(negedge clk);
        src_valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
    endtask

    function automatic logic [15:0] pick_digit();
        logic [7:0] lo;
        logic [7:0] hi;
        logic [7:0] borders [8] = '{8'h2f, 8'h3a, 8'h40, 8'h47, 8'h60, 8'h67, 8'h25, 8'h00};
        case ($urandom_range(0, 6))
            0, 1: lo = 8'h30 + 8'($urandom_range(0, 9));
            2:    lo = 8'h41 + 8'($urandom_range(0, 5));
            3:    lo = 8'h61 + 8'($urandom_range(0, 5));
            4:    lo = borders[$urandom_range(0, 7)];
            5:    lo = 8'($urandom);
            default: lo = ($urandom_range(0, 1) == 1) ? 8'h46 : 8'h30;
        endcase
        hi = ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'h00;
        return {hi, lo};
    endfunction

    function automatic logic [15:0] pick_plain();
        case ($urandom_range(0, 5))
            0:       return 16'($urandom);
            1:       return {8'($urandom_range(1, 255)), 8'h25};
            default: return 16'h0020 + 16'($urandom_range(0, 94));
        endcase
    endfunction

    initial
    begin
        int stall_len;
        wait (rst_n === 1'b1);
        forever
        begin
            stall_len = dst_quiet ? 0 : $urandom_range(0, 9);
            repeat (stall_len)
            begin
                @(negedge clk);
                dst_stall <= 1'b1;
            end
            @(negedge clk);
            dst_stall <= 1'b0;
            do
                @(posedge clk);
            while (dst_valid !== 1'b1);
            sb.check_result(dst_data);
        end
    end

    initial
    begin
        int n_strings;
        int len;
        rst_n <= 1'b0;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed strings
        str_q = '{16'h0041, 16'h0000, 16'hFFFF};
        send_string();
        str_q = '{PCT_CHAR, 16'h0030, 16'h0030, PCT_CHAR, 16'h0066, 16'h0046};
        send_string();
        str_q = '{PCT_CHAR, 16'h0034, 16'h007A, PCT_CHAR, 16'h007A, 16'h007A};
        send_string();
        str_q = '{PCT_CHAR};
        send_string();
        str_q = '{PCT_CHAR, 16'h0034};
        send_string();
        str_q = '{16'h0125, PCT_CHAR, 16'h1234, 16'hFF41, PCT_CHAR, PCT_CHAR, PCT_CHAR};
        send_string();
        drain();

        // random strings, mostly built from escapes and plain characters
        n_strings = 0;
        while (requests_sent < 470)
        begin
            src_quiet = ($urandom_range(0, 7) == 0);
            dst_quiet = ($urandom_range(0, 7) == 0);
            str_q.delete();
            len = $urandom_range(1, 10);
            if ($urandom_range(0, 9) == 0)
            begin
                repeat (len)
                    str_q.push_back(($urandom_range(0, 3) == 0) ? PCT_CHAR : 16'($urandom));
            end
            else
            begin
                while (str_q.size() < len)
                begin
                    if ($urandom_range(0, 99) < 40)
                    begin
                        str_q.push_back(PCT_CHAR);
                        str_q.push_back(pick_digit());
                        str_q.push_back(pick_digit());
                    end
                    else
                        str_q.push_back(pick_plain());
                end
                // now and then drop the last one or two characters, cutting short any trailing escape
                if ($urandom_range(0, 5) == 0 && str_q.size() > 2)
                    repeat ($urandom_range(1, 2)) void'(str_q.pop_back());
            end
            send_string();
            n_strings++;
            if (n_strings % 40 == 0)
                drain();
        end

        drain();
        src_quiet = 1'b0;
        dst_quiet = 1'b0;
        repeat (10) @(posedge clk);

        $display("%0d requests in %0d random strings, %0d results checked",
                 requests_sent, n_strings, sb.results_seen);
        $display("escapes: %0d full byte, %0d single digit, %0d bad, %0d cut short",
                 sb.n_decoded, sb.n_single, sb.n_bad, sb.n_cut);
        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("percent_escape_decoder verification clean");
        else
            $display("percent_escape_decoder verification failed");
        $finish;
    end

endmodule
